// ----- hdl/modexp_pkg.sv -----
package modexp_pkg;

   localparam int WIDTH = 32;
   localparam int CNT_W = $clog2(WIDTH);
   localparam int UPC_W = 4;
   localparam int IDX_W = 2;
   localparam int ST_W  = 2;

   // status codes
   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_NO_KEY    = 2'd1;
   localparam logic [ST_W-1:0] ST_TOO_LARGE = 2'd2;

   // register indexes
   localparam logic [IDX_W-1:0] REG_MODULUS = 2'd0;
   localparam logic [IDX_W-1:0] REG_PUB_EXP = 2'd1;
   localparam logic [IDX_W-1:0] REG_PRV_EXP = 2'd2;
   localparam logic [IDX_W-1:0] REG_LAMBDA  = 2'd3;

   // microprogram addresses
   localparam logic [UPC_W-1:0] U_IDLE    = 4'd0;
   localparam logic [UPC_W-1:0] U_LDRED   = 4'd1;
   localparam logic [UPC_W-1:0] U_SETBASE = 4'd2;
   localparam logic [UPC_W-1:0] U_SQ      = 4'd3;
   localparam logic [UPC_W-1:0] U_TEST    = 4'd4;
   localparam logic [UPC_W-1:0] U_TAKE    = 4'd5;
   localparam logic [UPC_W-1:0] U_NEXT    = 4'd6;
   localparam logic [UPC_W-1:0] U_OUT     = 4'd7;
   localparam logic [UPC_W-1:0] U_DBL     = 4'd8;
   localparam logic [UPC_W-1:0] U_ADD     = 4'd9;

   // datapath operations
   localparam logic [3:0] OP_NONE    = 4'd0;
   localparam logic [3:0] OP_ACCEPT  = 4'd1;
   localparam logic [3:0] OP_LDRED   = 4'd2;
   localparam logic [3:0] OP_SETBASE = 4'd3;
   localparam logic [3:0] OP_SQ      = 4'd4;
   localparam logic [3:0] OP_TEST    = 4'd5;
   localparam logic [3:0] OP_TAKE    = 4'd6;
   localparam logic [3:0] OP_NEXT    = 4'd7;
   localparam logic [3:0] OP_OUT     = 4'd8;
   localparam logic [3:0] OP_DBL     = 4'd9;
   localparam logic [3:0] OP_ADD     = 4'd10;

   // sequencing kinds
   localparam logic [2:0] J_SEQ    = 3'd0;
   localparam logic [2:0] J_ACCEPT = 3'd1;
   localparam logic [2:0] J_CALL   = 3'd2;
   localparam logic [2:0] J_BIT    = 3'd3;
   localparam logic [2:0] J_ECNT   = 3'd4;
   localparam logic [2:0] J_MLOOP  = 3'd5;
   localparam logic [2:0] J_OUTW   = 3'd6;

   typedef struct packed {
      logic [3:0]       op;
      logic [2:0]       jmp;
      logic [UPC_W-1:0] target;
   } ctrl_word_type;

   function automatic ctrl_word_type ucode(input logic [UPC_W-1:0] upc);
      ctrl_word_type cw;
      cw = '{op: OP_NONE, jmp: J_SEQ, target: U_IDLE};
      case (upc)
         U_IDLE:    cw = '{op: OP_ACCEPT,  jmp: J_ACCEPT, target: U_OUT};
         U_LDRED:   cw = '{op: OP_LDRED,   jmp: J_CALL,   target: U_DBL};
         U_SETBASE: cw = '{op: OP_SETBASE, jmp: J_SEQ,    target: U_IDLE};
         U_SQ:      cw = '{op: OP_SQ,      jmp: J_CALL,   target: U_DBL};
         U_TEST:    cw = '{op: OP_TEST,    jmp: J_BIT,    target: U_NEXT};
         U_TAKE:    cw = '{op: OP_TAKE,    jmp: J_SEQ,    target: U_IDLE};
         U_NEXT:    cw = '{op: OP_NEXT,    jmp: J_ECNT,   target: U_SQ};
         U_OUT:     cw = '{op: OP_OUT,     jmp: J_OUTW,   target: U_IDLE};
         U_DBL:     cw = '{op: OP_DBL,     jmp: J_SEQ,    target: U_IDLE};
         U_ADD:     cw = '{op: OP_ADD,     jmp: J_MLOOP,  target: U_DBL};
         default:   cw = '{op: OP_NONE,    jmp: J_OUTW,   target: U_IDLE};
      endcase
      return cw;
   endfunction

   // (a + b) mod n with a, b < n
   function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
                                                input logic [WIDTH-1:0] b,
                                                input logic [WIDTH-1:0] n);
      logic [WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, n}) begin
         s = s - {1'b0, n};
      end
      return s[WIDTH-1:0];
   endfunction

endpackage

// ----- hdl/modular_exponentiation.sv -----
// modular exponentiation, result = value ^ exponent mod modulus
// an error request goes straight to the output step; otherwise one extra modular
//   multiply is run for each set bit of the exponent
// one request at a time, bounded by the serial shift-and-add modular
//   multiplier (two add_mod steps per multiplier bit)
// reset: synchronous, active high; clears all csr registers and the sequencer
module modular_exponentiation (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic [modexp_pkg::IDX_W-1:0]            csr_index,
   input  logic [modexp_pkg::WIDTH-1:0]            csr_wdata,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_cmd,
   input  logic [modexp_pkg::WIDTH-1:0]            req_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [modexp_pkg::WIDTH-1:0]            rsp_result_value,
   output logic [modexp_pkg::ST_W-1:0]             rsp_status
);

   localparam logic [modexp_pkg::CNT_W-1:0] CNT_MAX =
      modexp_pkg::CNT_W'(modexp_pkg::WIDTH - 1);

   // csr registers
   logic [modexp_pkg::WIDTH-1:0] modulus_ff, pub_exp_ff, prv_exp_ff, lambda_ff;

   // sequencer
   logic [modexp_pkg::UPC_W-1:0] upc_ff, upc_in;
   logic [modexp_pkg::UPC_W-1:0] ret_ff, ret_in;
   modexp_pkg::ctrl_word_type    cw;

   // datapath
   logic [modexp_pkg::WIDTH-1:0] val_ff, val_in;    // latched input value
   logic [modexp_pkg::WIDTH-1:0] exp_ff, exp_in;    // exponent, msb first
   logic [modexp_pkg::WIDTH-1:0] base_ff, base_in;  // value mod n
   logic [modexp_pkg::WIDTH-1:0] acc_ff, acc_in;    // running power
   logic [modexp_pkg::WIDTH-1:0] mc_ff, mc_in;      // multiplicand
   logic [modexp_pkg::WIDTH-1:0] mp_ff, mp_in;      // multiplier, shifted out msb first
   logic [modexp_pkg::WIDTH-1:0] prod_ff, prod_in;  // partial product mod n
   logic [modexp_pkg::CNT_W-1:0] cnt_ff, cnt_in;    // multiplier bit count
   logic [modexp_pkg::CNT_W-1:0] ecnt_ff, ecnt_in;  // exponent bit count
   logic [modexp_pkg::ST_W-1:0]  st_ff, st_in;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [modexp_pkg::WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic [modexp_pkg::ST_W-1:0]  rsp_status_ff, rsp_status_in;

   logic                         accept;
   logic                         out_free;
   logic [modexp_pkg::WIDTH-1:0] one_mod;
   logic [modexp_pkg::ST_W-1:0]  req_st;

   assign cw        = modexp_pkg::ucode(upc_ff);
   assign req_ready = (upc_ff == modexp_pkg::U_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   // 1 mod n, zero for a modulus of one
   assign one_mod   = (modulus_ff == modexp_pkg::WIDTH'(1)) ? '0 : modexp_pkg::WIDTH'(1);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

   // request screening: missing key first, then lambda limit
   always_comb begin
      if (modulus_ff == '0) begin
         req_st = modexp_pkg::ST_NO_KEY;
      end else if (req_value > lambda_ff) begin
         req_st = modexp_pkg::ST_TOO_LARGE;
      end else begin
         req_st = modexp_pkg::ST_OK;
      end
   end

   // sequencer: next micro address
   always_comb begin
      upc_in = upc_ff + modexp_pkg::UPC_W'(1);
      ret_in = ret_ff;
      case (cw.jmp)
         modexp_pkg::J_SEQ: begin
            upc_in = upc_ff + modexp_pkg::UPC_W'(1);
         end
         modexp_pkg::J_ACCEPT: begin
            // stay until a request beat lands; errors go straight to output
            if (!accept) begin
               upc_in = upc_ff;
            end else if (req_st != modexp_pkg::ST_OK) begin
               upc_in = cw.target;
            end
         end
         modexp_pkg::J_CALL: begin
            ret_in = upc_ff + modexp_pkg::UPC_W'(1);
            upc_in = cw.target;
         end
         modexp_pkg::J_BIT: begin
            // exponent bit set: multiply by base, else skip to next bit
            if (exp_ff[modexp_pkg::WIDTH-1]) begin
               ret_in = upc_ff + modexp_pkg::UPC_W'(1);
               upc_in = modexp_pkg::U_DBL;
            end else begin
               upc_in = cw.target;
            end
         end
         modexp_pkg::J_ECNT: begin
            if (ecnt_ff != '0) begin
               upc_in = cw.target;
            end
         end
         modexp_pkg::J_MLOOP: begin
            upc_in = (cnt_ff == '0) ? ret_ff : cw.target;
         end
         modexp_pkg::J_OUTW: begin
            upc_in = out_free ? cw.target : upc_ff;
         end
         default: begin
            upc_in = modexp_pkg::U_IDLE;
         end
      endcase
   end

   // datapath driven by the control word
   always_comb begin
      val_in        = val_ff;
      exp_in        = exp_ff;
      base_in       = base_ff;
      acc_in        = acc_ff;
      mc_in         = mc_ff;
      mp_in         = mp_ff;
      prod_in       = prod_ff;
      cnt_in        = cnt_ff;
      ecnt_in       = ecnt_ff;
      st_in         = st_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      case (cw.op)
         modexp_pkg::OP_ACCEPT: begin
            if (accept) begin
               val_in  = req_value;
               exp_in  = req_cmd ? prv_exp_ff : pub_exp_ff;
               st_in   = req_st;
               acc_in  = '0;
               ecnt_in = CNT_MAX;
            end
         end
         modexp_pkg::OP_LDRED: begin
            // value mod n computed as (1 mod n) * value through the multiplier
            mc_in   = one_mod;
            mp_in   = val_ff;
            prod_in = '0;
            cnt_in  = CNT_MAX;
         end
         modexp_pkg::OP_SETBASE: begin
            base_in = prod_ff;
            acc_in  = one_mod;
         end
         modexp_pkg::OP_SQ: begin
            mc_in   = acc_ff;
            mp_in   = acc_ff;
            prod_in = '0;
            cnt_in  = CNT_MAX;
         end
         modexp_pkg::OP_TEST: begin
            // take the square, set up acc * base in case the bit is set
            acc_in  = prod_ff;
            mc_in   = base_ff;
            mp_in   = prod_ff;
            prod_in = '0;
            cnt_in  = CNT_MAX;
         end
         modexp_pkg::OP_TAKE: begin
            acc_in = prod_ff;
         end
         modexp_pkg::OP_NEXT: begin
            exp_in  = {exp_ff[modexp_pkg::WIDTH-2:0], 1'b0};
            ecnt_in = ecnt_ff - modexp_pkg::CNT_W'(1);
         end
         modexp_pkg::OP_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = acc_ff;
               rsp_status_in = st_ff;
            end
         end
         modexp_pkg::OP_DBL: begin
            prod_in = modexp_pkg::add_mod(prod_ff, prod_ff, modulus_ff);
         end
         modexp_pkg::OP_ADD: begin
            if (mp_ff[modexp_pkg::WIDTH-1]) begin
               prod_in = modexp_pkg::add_mod(prod_ff, mc_ff, modulus_ff);
            end
            mp_in  = {mp_ff[modexp_pkg::WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - modexp_pkg::CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= '0;
         pub_exp_ff <= '0;
         prv_exp_ff <= '0;
         lambda_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            modexp_pkg::REG_MODULUS: modulus_ff <= csr_wdata;
            modexp_pkg::REG_PUB_EXP: pub_exp_ff <= csr_wdata;
            modexp_pkg::REG_PRV_EXP: prv_exp_ff <= csr_wdata;
            modexp_pkg::REG_LAMBDA:  lambda_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= modexp_pkg::U_IDLE;
         ret_ff       <= modexp_pkg::U_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         ret_ff       <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      val_ff        <= val_in;
      exp_ff        <= exp_in;
      base_ff       <= base_in;
      acc_ff        <= acc_in;
      mc_ff         <= mc_in;
      mp_ff         <= mp_in;
      prod_ff       <= prod_in;
      cnt_ff        <= cnt_in;
      ecnt_ff       <= ecnt_in;
      st_ff         <= st_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

`ifndef ASSERT_OFF
   // a new response only follows the output step
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(upc_ff) == modexp_pkg::U_OUT)
      else $error("response raised outside output step");

   // errors always carry a zero result
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != modexp_pkg::ST_OK |-> rsp_value_ff == '0)
      else $error("nonzero result on error status");

   // partial product stays reduced inside the multiply loop
   a_prod_reduced: assert property (@(posedge clock) disable iff (reset)
      upc_ff == modexp_pkg::U_ADD |-> prod_ff < modulus_ff)
      else $error("partial product not reduced");

   // good results are below the modulus
   a_result_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == modexp_pkg::ST_OK |-> rsp_value_ff < modulus_ff)
      else $error("result not reduced");
`endif

endmodule
